### hdl/rrss_pkg.sv
package rrss_pkg;

    // input word fields
    typedef struct packed {
        logic [1:0]  func;
        logic [31:0] source_id;
        logic        switched;
        logic        force_stop;
    } rrss_item_t;

    // result word fields
    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] target_id;
        logic        resend;
        logic        stop_forced;
        logic        auto_switch;
        logic        last;
    } rrss_result_t;

    // operation codes
    localparam logic [1:0] FUNC_ACTIVATE   = 2'd0;
    localparam logic [1:0] FUNC_REACTIVATE = 2'd1;
    localparam logic [1:0] FUNC_DEACTIVATE = 2'd2;
    localparam logic [1:0] FUNC_TICK       = 2'd3;

    // action codes
    localparam logic [1:0] ACT_REQUEST   = 2'd0;
    localparam logic [1:0] ACT_UNREQUEST = 2'd1;
    localparam logic [1:0] ACT_STOP      = 2'd2;
    localparam logic [1:0] ACT_FULL      = 2'd3;

    // configuration register indexes
    localparam int unsigned CFG_IDX_W       = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_SEQ_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_DWELL      = 1'b1;

    localparam logic [31:0] DWELL_RESET = 32'd5000;
    localparam logic [31:0] TICKS_MAX   = 32'hFFFF_FFFF;

endpackage

### hdl/round_robin_source_sequencer.sv
// reactivate gives its result in the cycle after start; activate, tick and deactivate walk
// the list: search and shift run one entry per cycle through the list memory, then a
// registered read for the select
// throughput: one word at a time, busy drops in the cycle the last result is on the ports
// results are one-cycle strobes on result_valid; the receiver cannot stall them
// reset clears count, current source, timer and control and configuration registers; list memory is not cleared
module round_robin_source_sequencer
    import rrss_pkg::*;
#(
    parameter int unsigned MAX_SOURCES = 16
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    output logic                 busy,
    input  rrss_item_t           item,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    output rrss_result_t         result,
    output logic                 result_valid
);

    localparam int unsigned IDX_W = $clog2(MAX_SOURCES);
    localparam int unsigned CNT_W = $clog2(MAX_SOURCES + 1);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_SEARCH = 3'd1;
    localparam logic [2:0] S_SHIFT  = 3'd2;
    localparam logic [2:0] S_SELECT = 3'd3;
    localparam logic [2:0] S_RDSEL  = 3'd4;
    localparam logic [2:0] S_RDWAIT = 3'd5;
    localparam logic [2:0] S_EMIT2  = 3'd6;

    // state
    logic [2:0]       state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [31:0]      current_id_reg, current_id_next;
    logic             current_valid_reg, current_valid_next;
    logic [31:0]      elapsed_reg, elapsed_next;
    logic             seq_enable_reg;
    logic [31:0]      dwell_reg;

    // sequencer working registers
    rrss_item_t       item_reg, item_next;
    logic [31:0]      key_reg, key_next;
    logic [CNT_W-1:0] ptr_reg, ptr_next;
    logic             rdv_reg, rdv_next;
    logic [CNT_W-1:0] rd_idx_reg, rd_idx_next;
    logic [CNT_W-1:0] fidx_reg, fidx_next;
    logic [IDX_W-1:0] sel_reg, sel_next;
    rrss_result_t     result_reg, result_next;
    logic             result_valid_reg, result_valid_next;
    rrss_result_t     pend_reg, pend_next;

    // list memory
    logic [31:0]      mem [MAX_SOURCES];
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;
    logic [31:0]      mem_wdata;
    logic             mem_re;
    logic [IDX_W-1:0] mem_raddr;
    logic [31:0]      rdata_reg;

    // helpers
    logic [31:0]      elapsed_inc;
    logic             rotate;
    logic             hit;
    logic             miss;
    logic [CNT_W-1:0] next_idx;
    logic [CNT_W-1:0] shift_waddr;
    logic [CNT_W-1:0] rot_idx;

    function automatic rrss_result_t make_result(
        input logic [1:0]  action,
        input logic [31:0] id,
        input logic        resend,
        input logic        forced,
        input logic        autosw,
        input logic        last
    );
        rrss_result_t r;
        r.action      = action;
        r.target_id   = id;
        r.resend      = resend;
        r.stop_forced = forced;
        r.auto_switch = autosw;
        r.last        = last;
        return r;
    endfunction

    assign busy         = (state_reg != S_IDLE);
    assign result       = result_reg;
    assign result_valid = result_valid_reg;

    // saturating tick count and rotation condition
    assign elapsed_inc = (elapsed_reg == TICKS_MAX) ? elapsed_reg : elapsed_reg + 32'd1;
    assign rotate      = seq_enable_reg && (elapsed_inc > dwell_reg)
                         && (count_reg > CNT_W'(1));

    // compare of the entry read last cycle
    assign hit         = rdv_reg && (rdata_reg == key_reg);
    assign miss        = !rdv_reg && (ptr_reg >= count_reg);
    assign next_idx    = rd_idx_reg + CNT_W'(1);
    assign shift_waddr = rd_idx_reg - CNT_W'(1);
    assign rot_idx     = (hit && (next_idx < count_reg)) ? next_idx : '0;

    // sequencer
    always_comb
    begin
        state_next         = state_reg;
        count_next         = count_reg;
        current_id_next    = current_id_reg;
        current_valid_next = current_valid_reg;
        elapsed_next       = elapsed_reg;
        item_next          = item_reg;
        key_next           = key_reg;
        ptr_next           = ptr_reg;
        rdv_next           = 1'b0;
        rd_idx_next        = rd_idx_reg;
        fidx_next          = fidx_reg;
        sel_next           = sel_reg;
        result_next        = result_reg;
        result_valid_next  = 1'b0;
        pend_next          = pend_reg;
        mem_we             = 1'b0;
        mem_waddr          = '0;
        mem_wdata          = key_reg;
        mem_re             = 1'b0;
        mem_raddr          = ptr_reg[IDX_W-1:0];

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    item_next = item;
                    key_next  = item.source_id;
                    ptr_next  = '0;
                    case (item.func)
                        FUNC_ACTIVATE:
                        begin
                            state_next = S_SEARCH;
                        end
                        FUNC_REACTIVATE:
                        begin
                            result_next = make_result(ACT_REQUEST, item.source_id,
                                                      1'b1, 1'b0, 1'b0, 1'b1);
                            result_valid_next = 1'b1;
                            if (item.switched)
                            begin
                                current_id_next    = item.source_id;
                                current_valid_next = 1'b1;
                                elapsed_next       = '0;
                            end
                        end
                        FUNC_DEACTIVATE:
                        begin
                            if (current_valid_reg && (current_id_reg == item.source_id))
                            begin
                                result_next = make_result(ACT_UNREQUEST, item.source_id,
                                                          1'b0, item.force_stop, 1'b0, 1'b0);
                                result_valid_next = 1'b1;
                            end
                            state_next = S_SEARCH;
                        end
                        default:
                        begin
                            if (rotate)
                            begin
                                if (current_valid_reg)
                                begin
                                    key_next   = current_id_reg;
                                    state_next = S_SEARCH;
                                end
                                else
                                begin
                                    sel_next   = '0;
                                    state_next = S_RDSEL;
                                end
                            end
                            else
                            begin
                                elapsed_next = elapsed_inc;
                            end
                        end
                    endcase
                end
            end

            // linear search, one entry per cycle, compare in the cycle after the read
            S_SEARCH:
            begin
                mem_re      = (ptr_reg < count_reg);
                mem_raddr   = ptr_reg[IDX_W-1:0];
                rdv_next    = mem_re;
                rd_idx_next = ptr_reg;
                if (mem_re)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (hit || miss)
                begin
                    rdv_next = 1'b0;
                    mem_re   = 1'b0;
                    case (item_reg.func)
                        FUNC_ACTIVATE:
                        begin
                            current_id_next    = key_reg;
                            current_valid_next = 1'b1;
                            elapsed_next       = '0;
                            result_next = make_result(ACT_REQUEST, key_reg,
                                                      1'b0, 1'b0, 1'b0, 1'b1);
                            result_valid_next = 1'b1;
                            state_next        = S_IDLE;
                            if (!hit)
                            begin
                                if (count_reg < CNT_W'(MAX_SOURCES))
                                begin
                                    mem_we     = 1'b1;
                                    mem_waddr  = count_reg[IDX_W-1:0];
                                    mem_wdata  = key_reg;
                                    count_next = count_reg + CNT_W'(1);
                                end
                                else
                                begin
                                    pend_next   = result_next;
                                    result_next = make_result(ACT_FULL, key_reg,
                                                              1'b0, 1'b0, 1'b0, 1'b0);
                                    state_next  = S_EMIT2;
                                end
                            end
                        end
                        FUNC_DEACTIVATE:
                        begin
                            if (hit)
                            begin
                                fidx_next = rd_idx_reg;
                                if (next_idx < count_reg)
                                begin
                                    ptr_next   = next_idx;
                                    state_next = S_SHIFT;
                                end
                                else
                                begin
                                    count_next = count_reg - CNT_W'(1);
                                    state_next = S_SELECT;
                                end
                            end
                            else
                            begin
                                fidx_next  = count_reg;
                                state_next = S_SELECT;
                            end
                        end
                        default:
                        begin
                            sel_next   = rot_idx[IDX_W-1:0];
                            state_next = S_RDSEL;
                        end
                    endcase
                end
            end

            // close the gap: read entry k, write it to k-1 next cycle
            S_SHIFT:
            begin
                mem_re      = (ptr_reg < count_reg);
                mem_raddr   = ptr_reg[IDX_W-1:0];
                rdv_next    = mem_re;
                rd_idx_next = ptr_reg;
                if (mem_re)
                begin
                    ptr_next = ptr_reg + CNT_W'(1);
                end
                if (rdv_reg)
                begin
                    mem_we    = 1'b1;
                    mem_waddr = shift_waddr[IDX_W-1:0];
                    mem_wdata = rdata_reg;
                end
                if (!mem_re && !rdv_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                    state_next = S_SELECT;
                end
            end

            // pick the entry that moved into place (the first entry if none did), or stop on an empty list
            S_SELECT:
            begin
                if (count_reg == '0)
                begin
                    result_next = make_result(ACT_STOP, '0, 1'b0, 1'b0, 1'b0, 1'b1);
                    result_valid_next = 1'b1;
                    state_next        = S_IDLE;
                end
                else
                begin
                    sel_next   = (fidx_reg >= count_reg) ? '0 : fidx_reg[IDX_W-1:0];
                    state_next = S_RDSEL;
                end
            end

            S_RDSEL:
            begin
                mem_re     = 1'b1;
                mem_raddr  = sel_reg;
                state_next = S_RDWAIT;
            end

            // new current source from the list
            S_RDWAIT:
            begin
                current_id_next    = rdata_reg;
                current_valid_next = 1'b1;
                elapsed_next       = '0;
                result_next = make_result(ACT_REQUEST, rdata_reg,
                                          item_reg.func == FUNC_DEACTIVATE, 1'b0,
                                          item_reg.func == FUNC_TICK, 1'b1);
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end

            S_EMIT2:
            begin
                result_next       = pend_reg;
                result_valid_next = 1'b1;
                state_next        = S_IDLE;
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            count_reg         <= '0;
            current_id_reg    <= '0;
            current_valid_reg <= 1'b0;
            elapsed_reg       <= '0;
            ptr_reg           <= '0;
            rdv_reg           <= 1'b0;
            result_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg         <= state_next;
            count_reg         <= count_next;
            current_id_reg    <= current_id_next;
            current_valid_reg <= current_valid_next;
            elapsed_reg       <= elapsed_next;
            ptr_reg           <= ptr_next;
            rdv_reg           <= rdv_next;
            result_valid_reg  <= result_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        item_reg   <= item_next;
        key_reg    <= key_next;
        rd_idx_reg <= rd_idx_next;
        fidx_reg   <= fidx_next;
        sel_reg    <= sel_next;
        result_reg <= result_next;
        pend_reg   <= pend_next;
    end

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_enable_reg <= 1'b0;
            dwell_reg      <= DWELL_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_SEQ_ENABLE: seq_enable_reg <= cfg_data[0];
                CFG_DWELL:      dwell_reg      <= cfg_data;
                default:        seq_enable_reg <= seq_enable_reg;
            endcase
        end
    end

    // source list memory, registered read
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // checks
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_SOURCES))
        else $error("source count above list depth");

    a_full_then_request: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == ACT_FULL)
        |=> result_valid && (result.action == ACT_REQUEST) && result.last)
        else $error("table full notice not followed by request");

    a_full_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == ACT_FULL) |-> !result.last)
        else $error("table full notice marked last");

    a_stop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.action == ACT_STOP) |-> (count_reg == '0))
        else $error("stop issued with sources listed");

    a_reactivate_next: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && (item.func == FUNC_REACTIVATE)
        |=> result_valid && result.last && result.resend && !busy)
        else $error("reactivate result missing");

endmodule

### dv/round_robin_source_sequencer_test.sv
module round_robin_source_sequencer_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rrss_pkg::*;

    localparam int MAX_SRC     = 16;
    localparam int SETTLE      = 2 * MAX_SRC + 10;
    localparam int POOL_SIZE   = 20;
    localparam int NUM_PHASES  = 6;
    localparam int PHASE_ITEMS = 225;

    // one row of the directed table: a register write or a word to send
    typedef struct {
        bit                   is_cfg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [31:0]          reg_data;
        rrss_item_t           word;
        int                   n_typed;   // -1: take the predicted actions
        rrss_result_t         want0;
        rrss_result_t         want1;
    } stim_row_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    rrss_item_t           item_word = '0;
    logic                 cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [31:0]          cfg_data = '0;
    rrss_result_t         result_word;
    logic                 result_valid;

    // predictor state and register copies
    logic [31:0] src_list [MAX_SRC];
    int          src_count;
    logic [31:0] cur_id;
    logic        cur_valid;
    logic [31:0] elapsed;
    logic        seq_en;
    logic [31:0] dwell;

    rrss_result_t step_actions [$];
    rrss_result_t expected_actions [$];
    stim_row_t    dir_rows [$];
    logic [31:0]  id_pool [POOL_SIZE];
    int           fail_count = 0;

    round_robin_source_sequencer #(.MAX_SOURCES(MAX_SRC)) uut (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .item         (item_word),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .result       (result_word),
        .result_valid (result_valid)
    );

    // 4 ns clock
    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic rrss_item_t mk_item(input logic [1:0] f, input logic [31:0] id,
                                           input logic sw, input logic fs);
        rrss_item_t w;
        w.func       = f;
        w.source_id  = id;
        w.switched   = sw;
        w.force_stop = fs;
        return w;
    endfunction

    function automatic rrss_result_t mk_res(input logic [1:0] act, input logic [31:0] id,
                                            input logic rs, input logic sf, input logic au,
                                            input logic lst);
        rrss_result_t r;
        r.action      = act;
        r.target_id   = id;
        r.resend      = rs;
        r.stop_forced = sf;
        r.auto_switch = au;
        r.last        = lst;
        return r;
    endfunction

    // position of an id in the list, or the count when absent
    function automatic int find_src(input logic [31:0] id);
        for (int i = 0; i < src_count; i++)
        begin
            if (src_list[i] == id)
                return i;
        end
        return src_count;
    endfunction

    // actions that one accepted word causes, left in step_actions
    function automatic void schedule_actions(input rrss_item_t w);
        int           i;
        int           n;
        rrss_result_t tail;
        step_actions.delete();
        case (w.func)
            FUNC_ACTIVATE:
            begin
                if (find_src(w.source_id) == src_count)
                begin
                    if (src_count < MAX_SRC)
                    begin
                        src_list[src_count] = w.source_id;
                        src_count++;
                    end
                    else
                        step_actions.push_back(mk_res(ACT_FULL, w.source_id, 0, 0, 0, 0));
                end
                cur_id    = w.source_id;
                cur_valid = 1'b1;
                elapsed   = '0;
                step_actions.push_back(mk_res(ACT_REQUEST, w.source_id, 0, 0, 0, 0));
            end
            FUNC_REACTIVATE:
            begin
                step_actions.push_back(mk_res(ACT_REQUEST, w.source_id, 1, 0, 0, 0));
                if (w.switched)
                begin
                    cur_id    = w.source_id;
                    cur_valid = 1'b1;
                    elapsed   = '0;
                end
            end
            FUNC_DEACTIVATE:
            begin
                if (cur_valid && cur_id == w.source_id)
                    step_actions.push_back(mk_res(ACT_UNREQUEST, w.source_id, 0,
                                                  w.force_stop, 0, 0));
                i = find_src(w.source_id);
                if (i < src_count)
                begin
                    for (n = i; n + 1 < src_count; n++)
                        src_list[n] = src_list[n + 1];
                    src_count--;
                end
                if (src_count > 0)
                begin
                    n         = (i >= src_count) ? 0 : i;
                    cur_id    = src_list[n];
                    cur_valid = 1'b1;
                    elapsed   = '0;
                    step_actions.push_back(mk_res(ACT_REQUEST, cur_id, 1, 0, 0, 0));
                end
                else
                    step_actions.push_back(mk_res(ACT_STOP, '0, 0, 0, 0, 0));
            end
            default:
            begin
                // saturating tick, then round-robin rotation past the dwell time
                if (elapsed != TICKS_MAX)
                    elapsed++;
                if (seq_en && elapsed > dwell && src_count > 1)
                begin
                    n = 0;
                    if (cur_valid)
                    begin
                        i = find_src(cur_id);
                        if (i < src_count)
                            n = i + 1;
                    end
                    if (n >= src_count)
                        n = 0;
                    cur_id    = src_list[n];
                    cur_valid = 1'b1;
                    elapsed   = '0;
                    step_actions.push_back(mk_res(ACT_REQUEST, cur_id, 0, 0, 1, 0));
                end
            end
        endcase
        if (step_actions.size() > 0)
        begin
            tail      = step_actions.pop_back();
            tail.last = 1'b1;
            step_actions.push_back(tail);
        end
    endfunction

    // random word: mostly ids from a small pool so adds, hits and removals meet
    function automatic rrss_item_t random_word();
        int          r;
        logic [1:0]  f;
        logic [31:0] id;
        r = $urandom_range(0, 99);
        if (r < 25)
            f = FUNC_ACTIVATE;
        else if (r < 40)
            f = FUNC_REACTIVATE;
        else if (r < 60)
            f = FUNC_DEACTIVATE;
        else
            f = FUNC_TICK;
        if ($urandom_range(0, 9) < 8)
            id = id_pool[$urandom_range(0, POOL_SIZE - 1)];
        else
            id = $urandom;
        if (f == FUNC_DEACTIVATE && cur_valid && $urandom_range(0, 9) < 4)
            id = cur_id;
        return mk_item(f, id, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
    endfunction

    function automatic void add_op(input rrss_item_t w, input int n,
                                   input rrss_result_t a, input rrss_result_t b);
        stim_row_t row;
        row.is_cfg   = 1'b0;
        row.reg_idx  = '0;
        row.reg_data = '0;
        row.word     = w;
        row.n_typed  = n;
        row.want0    = a;
        row.want1    = b;
        dir_rows.push_back(row);
    endfunction

    function automatic void add_cfg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        stim_row_t row;
        row.is_cfg   = 1'b1;
        row.reg_idx  = idx;
        row.reg_data = data;
        row.word     = '0;
        row.n_typed  = 0;
        row.want0    = '0;
        row.want1    = '0;
        dir_rows.push_back(row);
    endfunction

    // directed table, starting from the reset state
    function automatic void build_directed();
        // deactivate on an empty list right after reset
        add_op(mk_item(FUNC_DEACTIVATE, 32'h0, 0, 0), 1, mk_res(ACT_STOP, 0, 0, 0, 0, 1), '0);
        // tick with rotation disabled
        add_op(mk_item(FUNC_TICK, 32'h0, 0, 0), 0, '0, '0);
        add_op(mk_item(FUNC_REACTIVATE, 32'hFFFF_FFFF, 0, 0), 1,
               mk_res(ACT_REQUEST, 32'hFFFF_FFFF, 1, 0, 0, 1), '0);
        add_op(mk_item(FUNC_ACTIVATE, 32'hFFFF_FFFF, 0, 0), 1,
               mk_res(ACT_REQUEST, 32'hFFFF_FFFF, 0, 0, 0, 1), '0);
        add_op(mk_item(FUNC_ACTIVATE, 32'h0, 0, 0), 1, mk_res(ACT_REQUEST, 0, 0, 0, 0, 1), '0);
        // duplicate add
        add_op(mk_item(FUNC_ACTIVATE, 32'h0, 1, 1), 1, mk_res(ACT_REQUEST, 0, 0, 0, 0, 1), '0);
        add_op(mk_item(FUNC_REACTIVATE, 32'h1234_5678, 1, 1), 1,
               mk_res(ACT_REQUEST, 32'h1234_5678, 1, 0, 0, 1), '0);
        // unrequest of the current unlisted id, then the first entry
        add_op(mk_item(FUNC_DEACTIVATE, 32'h1234_5678, 0, 1), 2,
               mk_res(ACT_UNREQUEST, 32'h1234_5678, 0, 1, 0, 0),
               mk_res(ACT_REQUEST, 32'hFFFF_FFFF, 1, 0, 0, 1));
        // fill the list
        for (int k = 1; k <= MAX_SRC - 2; k++)
            add_op(mk_item(FUNC_ACTIVATE, 32'h0001_0000 + k, k[0], k[1]), -1, '0, '0);
        // full list: notice first, then the request
        add_op(mk_item(FUNC_ACTIVATE, 32'hA5A5_A5A5, 0, 0), 2,
               mk_res(ACT_FULL, 32'hA5A5_A5A5, 0, 0, 0, 0),
               mk_res(ACT_REQUEST, 32'hA5A5_A5A5, 0, 0, 0, 1));
        add_op(mk_item(FUNC_DEACTIVATE, 32'h0, 0, 1), -1, '0, '0);
        // rotation with the shortest dwell
        add_cfg(CFG_SEQ_ENABLE, 32'd1);
        add_cfg(CFG_DWELL, 32'd0);
        add_op(mk_item(FUNC_TICK, 32'h0, 0, 0), -1, '0, '0);
        add_op(mk_item(FUNC_TICK, 32'hFFFF_FFFF, 1, 1), -1, '0, '0);
        // longest dwell never rotates
        add_cfg(CFG_DWELL, TICKS_MAX);
        add_op(mk_item(FUNC_TICK, 32'h0, 0, 0), 0, '0, '0);
        // current not in list when rotation comes
        add_op(mk_item(FUNC_REACTIVATE, 32'h5A5A_5A5A, 1, 0), -1, '0, '0);
        add_cfg(CFG_DWELL, 32'd0);
        add_op(mk_item(FUNC_TICK, 32'h0, 0, 0), -1, '0, '0);
    endfunction

    // send one word and queue what it should cause
    task automatic send_word(input rrss_item_t w, input int n_typed,
                             input rrss_result_t t0, input rrss_result_t t1);
        @(negedge clk);
        start     = 1'b1;
        item_word = w;
        forever
        begin
            @(posedge clk);
            if (!busy)
                break;
        end
        schedule_actions(w);
        if (n_typed < 0)
        begin
            foreach (step_actions[i])
                expected_actions.push_back(step_actions[i]);
        end
        else
        begin
            if (n_typed > 0)
                expected_actions.push_back(t0);
            if (n_typed > 1)
                expected_actions.push_back(t1);
        end
    endtask

    task automatic idle_for(input int gap);
        if (gap > 0)
        begin
            @(negedge clk);
            start = 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // wait until every expected word is in and the block has gone quiet
    task automatic drain();
        while (expected_actions.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] data);
        @(negedge clk);
        start = 1'b0;
        drain();
        @(negedge clk);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = data;
        @(negedge clk);
        cfg_we = 1'b0;
        if (idx == CFG_SEQ_ENABLE)
            seq_en = data[0];
        else
            dwell = data;
    endtask

    // result checker
    always @(posedge clk)
    begin
        rrss_result_t want;
        if (rst_n && result_valid)
        begin
            if (expected_actions.size() == 0)
            begin
                fail_count++;
                if (fail_count <= 10)
                    $display("unexpected word: act %0d id %h rs %b sf %b au %b last %b",
                             result_word.action, result_word.target_id, result_word.resend,
                             result_word.stop_forced, result_word.auto_switch,
                             result_word.last);
            end
            else
            begin
                want = expected_actions.pop_front();
                if (result_word.action !== want.action ||
                    result_word.target_id !== want.target_id ||
                    result_word.resend !== want.resend ||
                    result_word.stop_forced !== want.stop_forced ||
                    result_word.auto_switch !== want.auto_switch ||
                    result_word.last !== want.last)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                    begin
                        $write("mismatch: expected act %0d id %h rs %b sf %b au %b last %b,",
                               want.action, want.target_id, want.resend, want.stop_forced,
                               want.auto_switch, want.last);
                        $display(" got act %0d id %h rs %b sf %b au %b last %b",
                                 result_word.action, result_word.target_id,
                                 result_word.resend, result_word.stop_forced,
                                 result_word.auto_switch, result_word.last);
                    end
                end
            end
        end
    end

    // main sequence
    initial
    begin
        bit          phase_en [NUM_PHASES];
        logic [31:0] phase_dwell [NUM_PHASES];
        stim_row_t   row;
        int          burst;
        src_count = 0;
        cur_id    = '0;
        cur_valid = 1'b0;
        elapsed   = '0;
        seq_en    = 1'b0;
        dwell     = DWELL_RESET;
        id_pool[0] = 32'h0;
        id_pool[1] = 32'hFFFF_FFFF;
        for (int i = 2; i < POOL_SIZE; i++)
            id_pool[i] = $urandom;
        phase_en    = '{1, 1, 1, 0, 1, 1};
        phase_dwell = '{32'd0, 32'd2, TICKS_MAX, 32'd0, 32'd0, 32'd1};
        phase_dwell[4] = $urandom_range(3, 10);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed table
        build_directed();
        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            if (row.is_cfg)
                write_reg(row.reg_idx, row.reg_data);
            else
            begin
                send_word(row.word, row.n_typed, row.want0, row.want1);
                idle_for($urandom_range(0, 2));
            end
        end

        // random phases, bursty sender on even phases, back to back on odd ones
        for (int ph = 0; ph < NUM_PHASES; ph++)
        begin
            write_reg(CFG_SEQ_ENABLE, {31'd0, phase_en[ph]});
            write_reg(CFG_DWELL, phase_dwell[ph]);
            burst = $urandom_range(1, 12);
            for (int k = 0; k < PHASE_ITEMS; k++)
            begin
                send_word(random_word(), -1, '0, '0);
                burst--;
                if (burst == 0)
                begin
                    burst = $urandom_range(1, 12);
                    if (ph % 2 == 0)
                        idle_for($urandom_range(1, 8));
                end
            end
        end

        @(negedge clk);
        start = 1'b0;
        drain();
        if (fail_count == 0 && expected_actions.size() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    // watchdog
    initial
    begin
        #2_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
